### hdl/wpdm_pkg.sv
// ----------------------------------------------------------------------------
// wpdm_pkg: shared types and constants of the windowed PWM duty meter
// Payload structs, request codes, FSM states, widths and window limits.
// ----------------------------------------------------------------------------
package wpdm_pkg;

	localparam int TIME_BITS_DEF = 64;
	localparam int TS_W          = 64;
	localparam int WIN_W         = 30;
	localparam int ON_W          = WIN_W;
	localparam int ACC_W         = ON_W + 1;
	localparam int BRIGHT_W      = 16;
	localparam int PROD_W        = ACC_W + BRIGHT_W;

	localparam int QUEUE_DEPTH   = 2;
	localparam int QPTR_W        = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W        = $clog2(QUEUE_DEPTH + 1);

	localparam logic [WIN_W-1:0]    WIN_MIN    = WIN_W'(1000);
	localparam logic [WIN_W-1:0]    WIN_MAX    = WIN_W'(1000000000);
	localparam logic [WIN_W-1:0]    WIN_RESET  = WIN_W'(20000000);
	localparam logic [BRIGHT_W-1:0] FULL_SCALE = BRIGHT_W'(65535);

	typedef enum logic [0:0] {
		REQ_OBSERVE = 1'b0,
		REQ_QUERY   = 1'b1
	} req_t;

	typedef struct packed {
		req_t            req_type;
		logic [TS_W-1:0] timestamp_ns;
		logic            level_on;
	} in_item_t;

	typedef struct packed {
		logic [BRIGHT_W-1:0] brightness;
		logic                is_stable;
		logic [WIN_W-1:0]    period_ns;
		logic                current_on;
		logic                time_error;
	} out_item_t;

	// queue entry between front and back
	typedef struct packed {
		req_t            op;
		logic [TS_W-1:0] ts;
		logic            level;
	} q_entry_t;

	typedef enum logic [3:0] {
		BK_IDLE,
		BK_CMP,
		BK_LEFT,
		BK_CLOSE,
		BK_FURTHER,
		BK_DIV_MOD,
		BK_DIV_DUTY,
		BK_UPDATE,
		BK_IVAL,
		BK_RATIO,
		BK_DIV_RATIO,
		BK_DONE
	} back_state_t;

	// window length clamped to the legal range
	function automatic logic [WIN_W-1:0] win_sat(input logic [WIN_W-1:0] w);
		logic [WIN_W-1:0] r;
		priority if (w < WIN_MIN) begin
			r = WIN_MIN;
		end else if (w > WIN_MAX) begin
			r = WIN_MAX;
		end else begin
			r = w;
		end
		return r;
	endfunction

endpackage

### hdl/windowed_pwm_duty_meter.sv
// ----------------------------------------------------------------------------
// windowed_pwm_duty_meter: windowed PWM duty meter, top level
// Front queue, measurement engine and shared serial divider.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid / in_stall / in_data) carries observe or query
//   requests with a timestamp; each input transfer yields exactly one result
//   transfer on the output channel (out_valid / out_stall / out_data).
//   cfg_we / cfg_wdata writes the window length; write only while idle. A
//   write restarts the measurement but keeps the held level.
//   The front queues up to two requests, so in_stall rises only when the
//   queue is full. Requests are worked one at a time in the back end.
//   A division is needed when a window closes or the partial-window ratio
//   is reported; the serial divider then works one quotient bit per cycle.
//   The next request leaves the queue in the cycle after a result is
//   loaded, so the engine takes a new request only once the last result
//   is in the output register.
//   Reset: window 20 ms, all counters zero, level off, not stable, queue
//   and output register empty. A stalled result holds in the output
//   register; the engine waits on it and the queue keeps taking transfers.
// ----------------------------------------------------------------------------
module windowed_pwm_duty_meter #(
	parameter int TIME_BITS = wpdm_pkg::TIME_BITS_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_stall,
	input  wpdm_pkg::in_item_t          in_data,
	output logic                        out_valid,
	input  logic                        out_stall,
	output wpdm_pkg::out_item_t         out_data,
	input  logic                        cfg_we,
	input  logic [wpdm_pkg::WIN_W-1:0]  cfg_wdata
);
	import wpdm_pkg::*;

	// divider must hold both a full timestamp and an on-time product
	localparam int DIV_W = (TIME_BITS > PROD_W) ? TIME_BITS : PROD_W;

	logic                 q_valid;
	logic                 q_pop;
	req_t                 q_op;
	logic [TIME_BITS-1:0] q_time;
	logic                 q_level;

	logic                 div_start;
	logic [DIV_W-1:0]     div_dividend;
	logic [WIN_W-1:0]     div_divisor;
	logic                 div_done;
	logic [DIV_W-1:0]     div_quotient;
	logic [WIN_W-1:0]     div_remainder;

	// request queue
	wpdm_front #(
		.TIME_BITS (TIME_BITS)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.in_data  (in_data),
		.q_valid  (q_valid),
		.q_pop    (q_pop),
		.q_op     (q_op),
		.q_time   (q_time),
		.q_level  (q_level)
	);

	// measurement engine and output register
	wpdm_back #(
		.TIME_BITS (TIME_BITS),
		.DIV_W     (DIV_W)
	) u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_wdata     (cfg_wdata),
		.q_valid       (q_valid),
		.q_pop         (q_pop),
		.q_op          (q_op),
		.q_time        (q_time),
		.q_level       (q_level),
		.div_start     (div_start),
		.div_dividend  (div_dividend),
		.div_divisor   (div_divisor),
		.div_done      (div_done),
		.div_quotient  (div_quotient),
		.div_remainder (div_remainder),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.out_data      (out_data)
	);

	// shared by duty latch, whole-window skip and partial ratio
	wpdm_div #(
		.DIV_W (DIV_W)
	) u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (div_start),
		.dividend  (div_dividend),
		.divisor   (div_divisor),
		.done      (div_done),
		.quotient  (div_quotient),
		.remainder (div_remainder)
	);

endmodule

### hdl/wpdm_front.sv
// ----------------------------------------------------------------------------
// wpdm_front: input side of the duty meter
// Takes input transfers, classifies the request and holds them in a short queue.
// ----------------------------------------------------------------------------
module wpdm_front #(
	parameter int TIME_BITS = wpdm_pkg::TIME_BITS_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  wpdm_pkg::in_item_t   in_data,
	output logic                 q_valid,
	input  logic                 q_pop,
	output wpdm_pkg::req_t       q_op,
	output logic [TIME_BITS-1:0] q_time,
	output logic                 q_level
);
	import wpdm_pkg::*;

	q_entry_t          mem_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] cnt_q;
	logic              push;
	logic              pop;
	q_entry_t          entry;
	q_entry_t          head;

	assign in_stall = (cnt_q == QCNT_W'(QUEUE_DEPTH));
	assign push     = in_valid && !in_stall;
	assign q_valid  = (cnt_q != '0);
	assign pop      = q_pop && q_valid;

	// level only matters for an observe
	always_comb begin
		entry.op    = in_data.req_type;
		entry.ts    = in_data.timestamp_ns;
		entry.level = (in_data.req_type == REQ_OBSERVE) ? in_data.level_on : 1'b0;
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + QPTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + QPTR_W'(1);
			end
			unique case ({push, pop})
				2'b10:   cnt_q <= cnt_q + QCNT_W'(1);
				2'b01:   cnt_q <= cnt_q - QCNT_W'(1);
				default: cnt_q <= cnt_q;
			endcase
		end
	end

	assign head    = mem_q[rd_ptr_q];
	assign q_op    = head.op;
	assign q_time  = head.ts[TIME_BITS-1:0];
	assign q_level = head.level;

endmodule

### hdl/wpdm_div.sv
// ----------------------------------------------------------------------------
// wpdm_div: serial restoring divider
// One quotient bit per cycle; done pulses once quotient and remainder are valid.
// ----------------------------------------------------------------------------
module wpdm_div #(
	parameter int DIV_W = 64
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  logic [DIV_W-1:0]            dividend,
	input  logic [wpdm_pkg::WIN_W-1:0]  divisor,
	output logic                        done,
	output logic [DIV_W-1:0]            quotient,
	output logic [wpdm_pkg::WIN_W-1:0]  remainder
);
	import wpdm_pkg::*;

	localparam int CNT_W = $clog2(DIV_W);

	logic [DIV_W-1:0] quo_q;
	logic [WIN_W-1:0] rem_q;
	logic [WIN_W-1:0] dvs_q;
	logic [CNT_W-1:0] cnt_q;
	logic             busy_q;
	logic             done_q;
	logic [WIN_W:0]   trial;
	logic [WIN_W:0]   diff;
	logic             ge;

	assign trial = {rem_q, quo_q[DIV_W-1]};
	assign diff  = trial - {1'b0, dvs_q};
	assign ge    = (trial >= {1'b0, dvs_q});

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
			dvs_q <= divisor;
		end else if (busy_q) begin
			quo_q <= {quo_q[DIV_W-2:0], ge};
			rem_q <= ge ? diff[WIN_W-1:0] : trial[WIN_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + CNT_W'(1);
				if (cnt_q == CNT_W'(DIV_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	assign done      = done_q;
	assign quotient  = quo_q;
	assign remainder = rem_q;

endmodule

### hdl/wpdm_back.sv
// ----------------------------------------------------------------------------
// wpdm_back: measurement engine of the duty meter
// Holds the window state, credits elapsed time, closes windows through the
// shared divider and builds the result in an output register.
// ----------------------------------------------------------------------------
module wpdm_back #(
	parameter int TIME_BITS = wpdm_pkg::TIME_BITS_DEF,
	parameter int DIV_W     = wpdm_pkg::PROD_W
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_we,
	input  logic [wpdm_pkg::WIN_W-1:0]  cfg_wdata,
	input  logic                        q_valid,
	output logic                        q_pop,
	input  wpdm_pkg::req_t              q_op,
	input  logic [TIME_BITS-1:0]        q_time,
	input  logic                        q_level,
	output logic                        div_start,
	output logic [DIV_W-1:0]            div_dividend,
	output logic [wpdm_pkg::WIN_W-1:0]  div_divisor,
	input  logic                        div_done,
	input  logic [DIV_W-1:0]            div_quotient,
	input  logic [wpdm_pkg::WIN_W-1:0]  div_remainder,
	output logic                        out_valid,
	input  logic                        out_stall,
	output wpdm_pkg::out_item_t         out_data
);
	import wpdm_pkg::*;

	back_state_t state_q, state_d;

	// architectural state
	logic [WIN_W-1:0]     winu_q;
	logic [TIME_BITS-1:0] ws_q;
	logic [TIME_BITS-1:0] last_q;
	logic [ON_W-1:0]      on_q;
	logic [BRIGHT_W-1:0]  duty_q;
	logic                 held_q;
	logic                 stable_q;

	// per-item working registers
	logic [TIME_BITS-1:0] now_q;
	logic                 query_q;
	logic                 lvl_q;
	logic                 err_q;
	logic                 close_q;
	logic [TIME_BITS-1:0] el_q;
	logic [TIME_BITS-1:0] span_q;
	logic [WIN_W-1:0]     left_q;
	logic [ACC_W-1:0]     acc_q;
	logic [TIME_BITS-1:0] v_ws_q;
	logic [ON_W-1:0]      v_on_q;
	logic [BRIGHT_W-1:0]  v_duty_q;
	logic                 v_held_q;
	logic                 v_stable_q;
	logic [TIME_BITS-1:0] iv_q;
	logic [BRIGHT_W-1:0]  bright_q;

	out_item_t            out_q;
	logic                 out_valid_q;

	logic [TIME_BITS-1:0] winu_ext;
	logic [TIME_BITS-1:0] left_ext;
	logic [PROD_W-1:0]    prod_acc;
	logic [PROD_W-1:0]    prod_on;
	logic                 further;
	logic                 out_free;
	logic                 commit;
	logic [BRIGHT_W-1:0]  quo_sat;

	assign winu_ext = TIME_BITS'(winu_q);
	assign left_ext = TIME_BITS'(left_q);
	// x * 65535 as (x << 16) - x
	assign prod_acc = {acc_q, {BRIGHT_W{1'b0}}} - PROD_W'(acc_q);
	assign prod_on  = {1'b0, v_on_q, {BRIGHT_W{1'b0}}} - PROD_W'(v_on_q);
	assign further  = (el_q >= winu_ext);
	assign out_free = !out_valid_q || !out_stall;
	assign commit   = (state_q == BK_DONE) && out_free && !query_q && !err_q;
	assign quo_sat  = (|div_quotient[DIV_W-1:BRIGHT_W]) ? FULL_SCALE
	                                                    : div_quotient[BRIGHT_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= BK_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d      = state_q;
		q_pop        = 1'b0;
		div_start    = 1'b0;
		div_dividend = DIV_W'(prod_acc);
		div_divisor  = winu_q;
		unique case (state_q)
			BK_IDLE: begin
				if (q_valid) begin
					q_pop   = 1'b1;
					state_d = BK_CMP;
				end
			end
			BK_CMP: state_d = BK_LEFT;
			BK_LEFT: state_d = err_q ? BK_IVAL : BK_CLOSE;
			BK_CLOSE: state_d = (el_q >= left_ext) ? BK_FURTHER : BK_UPDATE;
			BK_FURTHER: begin
				div_start = 1'b1;
				if (further) begin
					div_dividend = DIV_W'(el_q);
					state_d      = BK_DIV_MOD;
				end else begin
					state_d = BK_DIV_DUTY;
				end
			end
			BK_DIV_MOD: begin
				if (div_done) begin
					state_d = BK_UPDATE;
				end
			end
			BK_DIV_DUTY: begin
				if (div_done) begin
					state_d = BK_UPDATE;
				end
			end
			BK_UPDATE: state_d = BK_IVAL;
			BK_IVAL: state_d = BK_RATIO;
			BK_RATIO: begin
				if (!v_stable_q && (iv_q != '0)) begin
					div_start    = 1'b1;
					div_dividend = DIV_W'(prod_on);
					div_divisor  = iv_q[WIN_W-1:0];
					state_d      = BK_DIV_RATIO;
				end else begin
					state_d = BK_DONE;
				end
			end
			BK_DIV_RATIO: begin
				if (div_done) begin
					state_d = BK_DONE;
				end
			end
			BK_DONE: begin
				if (out_free) begin
					state_d = BK_IDLE;
				end
			end
			default: state_d = BK_IDLE;
		endcase
	end

	// working datapath
	always_ff @(posedge clk) begin
		unique case (state_q)
			BK_IDLE: begin
				now_q   <= q_time;
				query_q <= (q_op == REQ_QUERY);
				lvl_q   <= q_level;
			end
			BK_CMP: begin
				err_q  <= (now_q < last_q);
				el_q   <= now_q - last_q;
				span_q <= last_q - ws_q;
			end
			BK_LEFT: begin
				v_ws_q     <= ws_q;
				v_on_q     <= on_q;
				v_duty_q   <= duty_q;
				v_held_q   <= held_q;
				v_stable_q <= stable_q;
				close_q    <= 1'b0;
				if (err_q) begin
					// report the state as seen at the last observation
					now_q <= last_q;
				end
				left_q <= (span_q < winu_ext) ? (winu_q - span_q[WIN_W-1:0]) : '0;
			end
			BK_CLOSE: begin
				if (el_q >= left_ext) begin
					close_q <= 1'b1;
					el_q    <= el_q - left_ext;
					acc_q   <= {1'b0, on_q} + (held_q ? {1'b0, left_q} : '0);
				end
			end
			BK_DIV_MOD: begin
				if (div_done) begin
					el_q     <= TIME_BITS'(div_remainder);
					v_duty_q <= held_q ? FULL_SCALE : '0;
				end
			end
			BK_DIV_DUTY: begin
				if (div_done) begin
					v_duty_q <= quo_sat;
				end
			end
			BK_UPDATE: begin
				if (close_q) begin
					v_ws_q     <= now_q - el_q;
					v_on_q     <= held_q ? el_q[ON_W-1:0] : '0;
					v_stable_q <= 1'b1;
				end else begin
					v_on_q <= on_q + (held_q ? el_q[ON_W-1:0] : '0);
				end
				v_held_q <= query_q ? held_q : lvl_q;
			end
			BK_IVAL: iv_q <= now_q - v_ws_q;
			BK_RATIO: begin
				if (v_stable_q) begin
					bright_q <= v_duty_q;
					iv_q     <= winu_ext;
				end else if (iv_q == '0) begin
					bright_q <= v_held_q ? FULL_SCALE : '0;
				end
			end
			BK_DIV_RATIO: begin
				if (div_done) begin
					bright_q <= quo_sat;
				end
			end
			BK_DONE: begin
				if (out_free) begin
					out_q.brightness <= bright_q;
					out_q.is_stable  <= v_stable_q;
					out_q.period_ns  <= iv_q[WIN_W-1:0];
					out_q.current_on <= v_held_q;
					out_q.time_error <= err_q;
				end
			end
			default: ;
		endcase
	end

	// measurement state and result handshake
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			winu_q      <= win_sat(WIN_RESET);
			ws_q        <= '0;
			last_q      <= '0;
			on_q        <= '0;
			duty_q      <= '0;
			held_q      <= 1'b0;
			stable_q    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				// new window restarts the measurement, level stays
				winu_q   <= win_sat(cfg_wdata);
				ws_q     <= last_q;
				on_q     <= '0;
				duty_q   <= '0;
				stable_q <= 1'b0;
			end else if (commit) begin
				ws_q     <= v_ws_q;
				last_q   <= now_q;
				on_q     <= v_on_q;
				duty_q   <= v_duty_q;
				held_q   <= v_held_q;
				stable_q <= v_stable_q;
			end
			if ((state_q == BK_DONE) && out_free) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

endmodule

### bench/tb_windowed_pwm_duty_meter.sv
// ----------------------------------------------------------------------------
// tb_windowed_pwm_duty_meter: self-checking bench for the PWM duty meter
// Drives observe and query requests through the valid/stall input channel,
// mirrors the meter in a behavioral predictor and checks every reading on
// the output channel field by field, across a series of window settings.
// ----------------------------------------------------------------------------
module tb_windowed_pwm_duty_meter;
	timeunit 1ns;
	timeprecision 1ps;

	import wpdm_pkg::*;

	localparam int CYCLE_LIMIT      = 800_000;
	localparam int SETTLE_CYCLES    = 100;   // a little over the slowest request
	localparam int PHASE_ITEMS      = 100;
	localparam int LONG_HOLD_AT     = 450;   // reading count that starts the long hold
	localparam int LONG_HOLD_CYCLES = 400;
	localparam int DRAIN_PHASE      = 2;
	localparam int DRAIN_ITEM       = 60;
	localparam int MAX_REPORTS      = 100;
	localparam logic [63:0] TIME_MAX = '1;

	// Mirror of the meter state; time fields are 64 bits wide, the on time wraps at 30 bits.
	typedef struct packed {
		logic [63:0]         start;     // current window start
		logic [63:0]         last;      // last observed time
		logic [63:0]         on_ns;     // on time inside the current window
		logic [BRIGHT_W-1:0] duty;      // latched duty
		logic                level;     // held level
		logic                stable;    // a full window was measured
	} meter_mirror_t;

	typedef struct packed {
		in_item_t sample;
		logic     drain;                // sender waits for all readings first
	} pending_sample_t;

	logic                clk;
	logic                arst_n    = 1'b0;
	logic                in_valid  = 1'b0;
	logic                in_stall;
	in_item_t            in_data   = '0;
	logic                out_valid;
	logic                out_stall = 1'b0;
	out_item_t           out_data;
	logic                cfg_we    = 1'b0;
	logic [WIN_W-1:0]    cfg_wdata = '0;

	meter_mirror_t       meter;
	logic [WIN_W-1:0]    window_reg;
	logic [63:0]         gen_time;          // latest observe time handed to the sender
	pending_sample_t     pending_samples[$];
	out_item_t           due_readings[$];

	int unsigned items_queued   = 0;
	int unsigned readings_seen  = 0;
	int unsigned mismatches     = 0;
	int unsigned error_readings = 0;
	int unsigned stable_readings = 0;
	int unsigned input_holds    = 0;
	int unsigned send_wait      = 0;
	int unsigned recv_wait      = 0;
	int unsigned cycles         = 0;
	bit          send_idle_on   = 1'b1;
	bit          recv_idle_on   = 1'b1;
	logic [WIN_W-1:0] window_plan [11];

	windowed_pwm_duty_meter uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// ------------------------------------------------------------------------
	// Predictor
	// ------------------------------------------------------------------------

	// Window actually used: register value clamped to the legal range.
	function automatic logic [63:0] window_in_use(logic [WIN_W-1:0] w);
		logic [63:0] r;
		r = 64'(w);
		if (r < 64'(WIN_MIN))
			r = 64'(WIN_MIN);
		else if (r > 64'(WIN_MAX))
			r = 64'(WIN_MAX);
		return r;
	endfunction

	// Credit the time from the last observation up to now to the held level,
	// closing the current window and skipping whole windows as needed.
	function automatic meter_mirror_t credit_elapsed(meter_mirror_t m, logic [63:0] now,
			logic [63:0] win);
		logic [63:0] elapsed, span, left, acc, d;
		elapsed = now - m.last;
		span    = m.last - m.start;
		left    = (span < win) ? win - span : 64'd0;
		if (elapsed >= left) begin
			acc      = m.on_ns + (m.level ? left : 64'd0);
			d        = acc * 64'(FULL_SCALE) / win;
			m.duty   = (d > 64'(FULL_SCALE)) ? FULL_SCALE : d[BRIGHT_W-1:0];
			m.stable = 1'b1;
			elapsed  = elapsed - left;
			m.start  = m.last + left;
			m.on_ns  = '0;
			// further whole windows: the duty follows the held level outright
			if (elapsed >= win) begin
				m.duty  = m.level ? FULL_SCALE : '0;
				m.start = m.start + elapsed / win * win;
				elapsed = elapsed % win;
			end
		end
		if (m.level)
			m.on_ns = m.on_ns + elapsed;
		m.on_ns = m.on_ns & 64'h3FFF_FFFF;
		m.last  = now;
		return m;
	endfunction

	// Reading as seen at time now: latched duty once stable, else the
	// partial-window on ratio.
	function automatic out_item_t reading_of(meter_mirror_t m, logic [63:0] now,
			logic [63:0] win);
		out_item_t   r;
		logic [63:0] iv, b;
		if (m.stable) begin
			b  = 64'(m.duty);
			iv = win;
		end else begin
			iv = now - m.start;
			if (iv != 0) begin
				b = m.on_ns * 64'(FULL_SCALE) / iv;
				if (b > 64'(FULL_SCALE))
					b = 64'(FULL_SCALE);
			end else begin
				b = m.level ? 64'(FULL_SCALE) : 64'd0;
			end
		end
		r.brightness = b[BRIGHT_W-1:0];
		r.is_stable  = m.stable;
		r.period_ns  = iv[WIN_W-1:0];
		r.current_on = m.level;
		r.time_error = 1'b0;
		return r;
	endfunction

	// Work out the reading for one accepted request and update the mirror.
	function automatic void predict_reading(in_item_t s);
		out_item_t   r;
		logic [63:0] win, now;
		win = window_in_use(window_reg);
		now = s.timestamp_ns;
		if (now < meter.last) begin
			// time went backwards: state untouched, report as of the last time
			r = reading_of(meter, meter.last, win);
			r.time_error = 1'b1;
		end else if (s.req_type == REQ_QUERY) begin
			r = reading_of(credit_elapsed(meter, now, win), now, win);
		end else begin
			meter       = credit_elapsed(meter, now, win);
			meter.level = s.level_on;
			r           = reading_of(meter, now, win);
		end
		due_readings = {due_readings, r};
	endfunction

	// A window write restarts the measurement; the held level survives.
	function automatic void load_window(logic [WIN_W-1:0] v);
		window_reg   = v;
		meter.start  = meter.last;
		meter.on_ns  = '0;
		meter.duty   = '0;
		meter.stable = 1'b0;
	endfunction

	// ------------------------------------------------------------------------
	// Stimulus
	// ------------------------------------------------------------------------

	function automatic void queue_sample(req_t op, logic [63:0] ts, logic lvl, logic drain);
		pending_sample_t e;
		e.sample.req_type     = op;
		e.sample.timestamp_ns = ts;
		e.sample.level_on     = lvl;
		e.drain               = drain;
		pending_samples = {pending_samples, e};
		items_queued++;
		if (op == REQ_OBSERVE && ts >= gen_time)
			gen_time = ts;
	endfunction

	// Mostly forward-moving observes with a spread of step sizes relative to
	// the window, plus queries (some far in the future) and backward stamps.
	function automatic void queue_random_sample(logic drain);
		logic [63:0] win, r, step;
		int unsigned w32, pick, sub;
		logic        lvl;
		win  = window_in_use(window_reg);
		w32  = win[31:0];
		pick = $urandom_range(0, 99);
		sub  = $urandom_range(0, 99);
		r    = {$urandom, $urandom};
		lvl  = 1'($urandom_range(0, 1));
		if (pick < 60) begin
			if (sub < 8)
				step = '0;
			else if (sub < 70)
				step = 64'($urandom_range(0, w32 / 4));
			else if (sub < 90)
				step = 64'($urandom_range(0, w32));
			else if (sub < 98)
				step = 64'($urandom_range(w32, 4 * w32));
			else
				step = {24'd0, r[39:0]};
			queue_sample(REQ_OBSERVE, gen_time + step, lvl, drain);
		end else if (pick < 75) begin
			queue_sample(REQ_QUERY, gen_time + 64'($urandom_range(0, w32)), lvl, drain);
		end else if (pick < 85) begin
			queue_sample(REQ_QUERY, (r < gen_time) ? gen_time : r, lvl, drain);
		end else if (pick < 95 && gen_time != 0) begin
			queue_sample(r[63] ? REQ_QUERY : REQ_OBSERVE, r % gen_time, lvl, drain);
		end else begin
			queue_sample(r[0] ? REQ_QUERY : REQ_OBSERVE, gen_time, lvl, drain);
		end
	endfunction

	// ------------------------------------------------------------------------
	// Driver: offers queued requests, with a random wait before each one and
	// an optional pause until every reading is back.
	// ------------------------------------------------------------------------
	always @(posedge clk) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else begin
			if (in_valid && in_stall)
				input_holds++;
			if (in_valid && !in_stall) begin
				predict_reading(in_data);
				send_wait = send_idle_on ? $urandom_range(0, 5) : 0;
				if ($urandom_range(0, 39) == 0)
					send_idle_on = !send_idle_on;
			end
			if (in_valid && in_stall) begin
				// stalled transfer: valid and payload stay as they are
			end else if (send_wait > 0) begin
				send_wait--;
				in_valid <= 1'b0;
			end else if (pending_samples.size() != 0 &&
					!(pending_samples[0].drain && due_readings.size() != 0)) begin
				in_data  <= pending_samples[0].sample;
				in_valid <= 1'b1;
				pending_samples.pop_front();
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// ------------------------------------------------------------------------
	// Monitor: checks each reading against the oldest prediction and stalls
	// the output at random, once for a long stretch so the queue fills up.
	// ------------------------------------------------------------------------
	function automatic void compare_field(string name, logic [63:0] want, logic [63:0] got);
		if (want !== got) begin
			mismatches++;
			if (mismatches <= MAX_REPORTS)
				$display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
		end
	endfunction

	function automatic void check_reading(out_item_t got);
		out_item_t want;
		if (due_readings.size() == 0) begin
			mismatches++;
			if (mismatches <= MAX_REPORTS)
				$display("%0t: reading with nothing expected, expected none, actual %p",
					$time, got);
		end else begin
			want = due_readings.pop_front();
			compare_field("brightness", 64'(want.brightness), 64'(got.brightness));
			compare_field("is_stable",  64'(want.is_stable),  64'(got.is_stable));
			compare_field("period_ns",  64'(want.period_ns),  64'(got.period_ns));
			compare_field("current_on", 64'(want.current_on), 64'(got.current_on));
			compare_field("time_error", 64'(want.time_error), 64'(got.time_error));
			if (want.time_error)
				error_readings++;
			if (want.is_stable)
				stable_readings++;
		end
	endfunction

	always @(posedge clk) begin
		if (!arst_n) begin
			out_stall <= 1'b0;
		end else begin
			if (out_valid && !out_stall) begin
				check_reading(out_data);
				readings_seen++;
				recv_wait = recv_idle_on ? $urandom_range(0, 5) : 0;
				if ($urandom_range(0, 39) == 0)
					recv_idle_on = !recv_idle_on;
				// long hold: the sender keeps offering, so in_stall must rise
				if (readings_seen == LONG_HOLD_AT)
					recv_wait = LONG_HOLD_CYCLES;
			end
			if (recv_wait > 0) begin
				recv_wait--;
				out_stall <= 1'b1;
			end else begin
				out_stall <= 1'b0;
			end
		end
	end

	// Watchdog
	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("%0t: timeout after %0d cycles", $time, cycles);
			$display("Test completed with failures");
			$finish;
		end
	end

	// ------------------------------------------------------------------------
	// Sequencing
	// ------------------------------------------------------------------------

	// Idle means every queued request has produced its reading; a further
	// wait of SETTLE_CYCLES lets the engine return to its idle state.
	task automatic settle();
		while (readings_seen != items_queued)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_window(logic [WIN_W-1:0] v);
		@(posedge clk);
		cfg_we    <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_we    <= 1'b0;
		load_window(v);
	endtask

	initial begin
		meter      = '0;
		window_reg = WIN_RESET;
		gen_time   = '0;

		window_plan[0]  = WIN_W'(1000);
		window_plan[1]  = WIN_W'(999);            // below range, clamps up
		window_plan[2]  = '0;
		window_plan[3]  = WIN_W'(1_000_000_000);
		window_plan[4]  = WIN_W'(1_000_000_001);  // above range, clamps down
		window_plan[5]  = '1;
		window_plan[6]  = WIN_W'($urandom_range(1000, 100_000));
		window_plan[7]  = WIN_W'($urandom_range(1000, 1_000_000_000));
		window_plan[8]  = WIN_W'($urandom_range(1000, 1_000_000_000));
		window_plan[9]  = WIN_W'(50_000);
		window_plan[10] = WIN_W'(20_000_000);

		repeat (6) @(posedge clk);
		arst_n <= 1'b1;

		// Directed pass on the reset window of 20 ms.
		queue_sample(REQ_QUERY,   64'd0,           1'b0, 1'b0); // zero-length window, off
		queue_sample(REQ_OBSERVE, 64'd0,           1'b1, 1'b0); // zero-length window, on
		queue_sample(REQ_QUERY,   64'd0,           1'b0, 1'b0); // level ignored on query
		queue_sample(REQ_OBSERVE, 64'd5_000_000,   1'b0, 1'b0); // partial ratio, full on
		queue_sample(REQ_OBSERVE, 64'd10_000_000,  1'b1, 1'b0);
		queue_sample(REQ_QUERY,   64'd15_000_000,  1'b0, 1'b0);
		queue_sample(REQ_OBSERVE, 64'd20_000_000,  1'b0, 1'b0); // window closes exactly
		queue_sample(REQ_OBSERVE, 64'd20_000_000,  1'b1, 1'b0); // same timestamp again
		queue_sample(REQ_OBSERVE, 64'd100_000_000, 1'b0, 1'b0); // whole windows while on
		queue_sample(REQ_OBSERVE, 64'd200_000_000, 1'b1, 1'b0); // whole windows while off
		queue_sample(REQ_OBSERVE, 64'd150_000_000, 1'b0, 1'b0); // backwards observe
		queue_sample(REQ_QUERY,   TIME_MAX,        1'b0, 1'b0); // query at the top of time
		queue_sample(REQ_QUERY,   64'd199_000_000, 1'b1, 1'b0); // backwards query
		queue_sample(REQ_OBSERVE, 64'd205_000_000, 1'b0, 1'b0);
		queue_sample(REQ_OBSERVE, 64'd219_999_999, 1'b1, 1'b0);
		queue_sample(REQ_QUERY,   TIME_MAX,        1'b1, 1'b0);
		queue_sample(REQ_OBSERVE, 64'd219_999_999, 1'b0, 1'b0);
		settle();

		// Random phases, one per window setting, written while idle.
		foreach (window_plan[p]) begin
			write_window(window_plan[p]);
			for (int i = 0; i < PHASE_ITEMS; i++)
				queue_random_sample(p == DRAIN_PHASE && i == DRAIN_ITEM);
			settle();
		end

		// Late phase: climb into the upper half of the time range and end at
		// the largest stamp, then throw backward stamps spread over all bits.
		queue_sample(REQ_OBSERVE, 64'h4000_0000_0000_0000 | 64'({$urandom, $urandom}),
			1'b1, 1'b0);
		for (int i = 0; i < 10; i++)
			queue_random_sample(1'b0);
		queue_sample(REQ_OBSERVE, 64'h8000_0000_0000_0000 | 64'({$urandom, $urandom}),
			1'b0, 1'b0);
		queue_sample(REQ_OBSERVE, TIME_MAX - 64'd1, 1'b1, 1'b0);
		queue_sample(REQ_OBSERVE, TIME_MAX,         1'b1, 1'b0);
		queue_sample(REQ_QUERY,   TIME_MAX,         1'b0, 1'b0);
		for (int i = 0; i < 20; i++)
			queue_random_sample(1'b0);
		settle();

		$display("Checked %0d readings over %0d window settings: %0d stable, %0d time errors.",
			readings_seen, $size(window_plan) + 1, stable_readings, error_readings);
		$display("Input channel held off for %0d cycles, %0d mismatches.",
			input_holds, mismatches);
		if (mismatches == 0 && due_readings.size() == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule

### sim.f
hdl/wpdm_pkg.sv
hdl/wpdm_front.sv
hdl/wpdm_div.sv
hdl/wpdm_back.sv
hdl/windowed_pwm_duty_meter.sv
bench/tb_windowed_pwm_duty_meter.sv
